// ===== hdl/two_level_btb_fill_lru_top_assert.svh =====
// Assertion macros shared by the branch target buffer RTL.
`ifndef TWO_LEVEL_BTB_FILL_LRU_TOP_ASSERT_SVH
`define TWO_LEVEL_BTB_FILL_LRU_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BTBF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("btbf assertion failed");
`define BTBF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("btbf assertion failed");
`else
`define BTBF_ASSERT(lbl, clk, rst, prop)
`define BTBF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/btbf_pkg.sv =====
package btbf_pkg;

   localparam int ADDR_BITS      = 64;
   localparam int L1_SET_BITS    = 6;
   localparam int L1_WAYS        = 4;
   localparam int L1_WAY_BITS    = 2;
   localparam int L1_TAG_BITS    = ADDR_BITS - 2 - L1_SET_BITS;
   localparam int L1_DATA_BITS   = L1_TAG_BITS + ADDR_BITS;
   localparam int L2_SET_BITS    = 10;
   localparam int L2_WAYS        = 8;
   localparam int L2_WAY_BITS    = 3;
   localparam int L2_TAG_BITS    = 16;
   localparam int L2_TARGET_BITS = 32;
   localparam int L2_DATA_BITS   = L2_TAG_BITS + L2_TARGET_BITS;
   localparam int SLICE_BITS     = 14;
   localparam int CLR_BITS       = (L1_SET_BITS > L2_SET_BITS) ? L1_SET_BITS : L2_SET_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam logic KIND_FILL   = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [1:0] LEVEL_L1   = 2'd0;
   localparam logic [1:0] LEVEL_L2   = 2'd1;
   localparam logic [1:0] LEVEL_BOTH = 2'd2;
   localparam logic [1:0] LEVEL_NONE = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic                      kind;
      logic [1:0]                level;
      logic [L1_SET_BITS-1:0]    l1_set;
      logic [L1_TAG_BITS-1:0]    l1_key;
      logic [L2_SET_BITS-1:0]    l2_set;
      logic [L2_TAG_BITS-1:0]    l2_key;
      logic [ADDR_BITS-1:0]      target;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } ctrl_type;

   typedef struct packed {
      logic [L1_WAYS-1:0]                  valid;
      logic [L1_WAYS-1:0][L1_WAY_BITS-1:0] age;
   } l1_meta_type;

   typedef struct packed {
      logic [L2_WAYS-1:0]                  valid;
      logic [L2_WAYS-1:0][L2_WAY_BITS-1:0] age;
   } l2_meta_type;

   localparam int L1_META_BITS = $bits(l1_meta_type);
   localparam int L2_META_BITS = $bits(l2_meta_type);

   function automatic l1_meta_type l1_meta_reset();
      l1_meta_type m;
      m.valid = '0;
      for (int w = 0; w < L1_WAYS; w++) begin
         m.age[w] = L1_WAY_BITS'(w);
      end
      return m;
   endfunction

   function automatic l2_meta_type l2_meta_reset();
      l2_meta_type m;
      m.valid = '0;
      for (int w = 0; w < L2_WAYS; w++) begin
         m.age[w] = L2_WAY_BITS'(w);
      end
      return m;
   endfunction

endpackage

// ===== hdl/btbf_req_if.sv =====
interface btbf_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [1:0]                      level;
   logic [btbf_pkg::ADDR_BITS-1:0]  branch_address;
   logic [btbf_pkg::ADDR_BITS-1:0]  jump_target;

   modport source (output valid, kind, level, branch_address, jump_target, input ready);
   modport sink   (input valid, kind, level, branch_address, jump_target, output ready);
endinterface

// ===== hdl/btbf_rsp_if.sv =====
interface btbf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 l1_hit;
   logic [btbf_pkg::L1_WAY_BITS-1:0]     l1_way;
   logic [btbf_pkg::ADDR_BITS-1:0]       l1_stored_target;
   logic                                 l2_hit;
   logic [btbf_pkg::L2_WAY_BITS-1:0]     l2_way;
   logic [btbf_pkg::L2_TARGET_BITS-1:0]  l2_stored_target;

   modport source (output valid, l1_hit, l1_way, l1_stored_target, l2_hit, l2_way,
                   l2_stored_target, input ready);
   modport sink   (input valid, l1_hit, l1_way, l1_stored_target, l2_hit, l2_way,
                   l2_stored_target, output ready);
endinterface

// ===== hdl/btbf_ram.sv =====
module btbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/btbf_front.sv =====
module btbf_front (
   input  logic                clock,
   input  logic                reset,
   btbf_req_if.sink            req_if,
   input  btbf_pkg::ctrl_type  ctrl,
   output btbf_pkg::head_type  head
);
   btbf_pkg::item_type entry_ff [btbf_pkg::QUEUE_DEPTH];
   logic [btbf_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [btbf_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   btbf_pkg::item_type new_item;
   logic push;
   logic [btbf_pkg::SLICE_BITS-1:0] lo_slice, hi_slice, mixed;

   // Split the address into the set and tag of each level.
   always_comb begin
      lo_slice = req_if.branch_address[2 +: btbf_pkg::SLICE_BITS];
      hi_slice = req_if.branch_address[2 + btbf_pkg::SLICE_BITS +: btbf_pkg::SLICE_BITS];
      mixed    = lo_slice ^ hi_slice;
      new_item.kind   = req_if.kind;
      new_item.level  = req_if.level;
      new_item.l1_set = req_if.branch_address[2 +: btbf_pkg::L1_SET_BITS];
      new_item.l1_key = req_if.branch_address[btbf_pkg::ADDR_BITS-1:2+btbf_pkg::L1_SET_BITS];
      new_item.l2_set = mixed[btbf_pkg::L2_SET_BITS-1:0];
      new_item.l2_key = req_if.branch_address[2 +: btbf_pkg::L2_TAG_BITS];
      new_item.target = req_if.jump_target;
   end

   assign req_if.ready = (count_ff != btbf_pkg::QUEUE_CNT_BITS'(btbf_pkg::QUEUE_DEPTH))
                         && !ctrl.clearing;
   assign push = req_if.valid && req_if.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = ctrl.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + btbf_pkg::QUEUE_CNT_BITS'(push)
                  - btbf_pkg::QUEUE_CNT_BITS'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];
endmodule

// ===== hdl/btbf_back.sv =====
module btbf_back (
   input  logic                clock,
   input  logic                reset,
   input  btbf_pkg::head_type  head,
   output btbf_pkg::ctrl_type  ctrl,
   btbf_rsp_if.source          rsp_if
);
   btbf_pkg::state_type state_ff, state_in;
   logic [btbf_pkg::CLR_BITS-1:0] clr_idx_ff, clr_idx_in;
   btbf_pkg::item_type cur_ff, cur_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 l1_hit_ff, l1_hit_in, l2_hit_ff, l2_hit_in;
   logic [btbf_pkg::L1_WAY_BITS-1:0]     l1_way_ff, l1_way_in;
   logic [btbf_pkg::L2_WAY_BITS-1:0]     l2_way_ff, l2_way_in;
   logic [btbf_pkg::ADDR_BITS-1:0]       l1_tgt_ff, l1_tgt_in;
   logic [btbf_pkg::L2_TARGET_BITS-1:0]  l2_tgt_ff, l2_tgt_in;

   logic out_free, commit, lookup, en1, en2;
   logic [btbf_pkg::L1_SET_BITS-1:0] l1_rd_addr, l1_wr_addr;
   logic [btbf_pkg::L2_SET_BITS-1:0] l2_rd_addr, l2_wr_addr;
   btbf_pkg::l1_meta_type l1_meta_rd, l1_meta_wr;
   btbf_pkg::l2_meta_type l2_meta_rd, l2_meta_wr;
   logic l1_meta_we, l2_meta_we;
   logic [btbf_pkg::L1_DATA_BITS-1:0] l1_data_rd [btbf_pkg::L1_WAYS];
   logic [btbf_pkg::L2_DATA_BITS-1:0] l2_data_rd [btbf_pkg::L2_WAYS];
   logic [btbf_pkg::L1_WAYS-1:0] l1_data_we;
   logic [btbf_pkg::L2_WAYS-1:0] l2_data_we;

   logic l1_hit, l1_inv, l2_hit, l2_inv;
   logic [btbf_pkg::L1_WAY_BITS-1:0] l1_mway, l1_iway, l1_oway, l1_pick, l1_mine;
   logic [btbf_pkg::L2_WAY_BITS-1:0] l2_mway, l2_iway, l2_oway, l2_pick, l2_mine;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btbf_pkg::ST_CLEAR: if (clr_idx_ff == '1) state_in = btbf_pkg::ST_IDLE;
         btbf_pkg::ST_IDLE:  if (head.valid) state_in = btbf_pkg::ST_EVAL;
         btbf_pkg::ST_EVAL:  if (out_free) state_in = btbf_pkg::ST_IDLE;
         default:            state_in = btbf_pkg::ST_CLEAR;
      endcase
   end

   // Control outputs.
   always_comb begin
      ctrl.pop      = 1'b0;
      ctrl.clearing = 1'b0;
      commit        = 1'b0;
      unique case (state_ff)
         btbf_pkg::ST_CLEAR: ctrl.clearing = 1'b1;
         btbf_pkg::ST_IDLE:  ctrl.pop = head.valid;
         btbf_pkg::ST_EVAL:  commit = out_free;
         default:            ctrl.clearing = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign cur_in   = ctrl.pop ? head.item : cur_ff;
   assign clr_idx_in = ctrl.clearing ? clr_idx_ff + 1'b1 : clr_idx_ff;

   assign l1_rd_addr = (state_ff == btbf_pkg::ST_IDLE) ? head.item.l1_set : cur_ff.l1_set;
   assign l2_rd_addr = (state_ff == btbf_pkg::ST_IDLE) ? head.item.l2_set : cur_ff.l2_set;
   assign l1_wr_addr = ctrl.clearing ? clr_idx_ff[btbf_pkg::L1_SET_BITS-1:0] : cur_ff.l1_set;
   assign l2_wr_addr = ctrl.clearing ? clr_idx_ff[btbf_pkg::L2_SET_BITS-1:0] : cur_ff.l2_set;

   assign lookup = (cur_ff.kind == btbf_pkg::KIND_LOOKUP);
   assign en1 = (cur_ff.level == btbf_pkg::LEVEL_L1) || (cur_ff.level == btbf_pkg::LEVEL_BOTH);
   assign en2 = (cur_ff.level == btbf_pkg::LEVEL_L2) || (cur_ff.level == btbf_pkg::LEVEL_BOTH);

   // Level 1 match, victim choice and age update.
   always_comb begin
      l1_hit = 1'b0; l1_mway = '0; l1_inv = 1'b0; l1_iway = '0; l1_oway = '0;
      for (int w = btbf_pkg::L1_WAYS - 1; w >= 0; w--) begin
         if (l1_meta_rd.valid[w] && (l1_data_rd[w][btbf_pkg::L1_DATA_BITS-1:btbf_pkg::ADDR_BITS]
                                     == cur_ff.l1_key)) begin
            l1_hit = 1'b1; l1_mway = btbf_pkg::L1_WAY_BITS'(w);
         end
         if (!l1_meta_rd.valid[w]) begin
            l1_inv = 1'b1; l1_iway = btbf_pkg::L1_WAY_BITS'(w);
         end
         if (l1_meta_rd.age[w] == btbf_pkg::L1_WAY_BITS'(btbf_pkg::L1_WAYS - 1)) begin
            l1_oway = btbf_pkg::L1_WAY_BITS'(w);
         end
      end
      l1_pick = l1_hit ? l1_mway : (l1_inv ? l1_iway : l1_oway);
      l1_mine = l1_meta_rd.age[l1_pick];
      l1_meta_wr = l1_meta_rd;
      for (int w = 0; w < btbf_pkg::L1_WAYS; w++) begin
         if (btbf_pkg::L1_WAY_BITS'(w) == l1_pick) begin
            l1_meta_wr.age[w]   = '0;
            l1_meta_wr.valid[w] = 1'b1;
         end else if (l1_meta_rd.age[w] < l1_mine) begin
            l1_meta_wr.age[w] = l1_meta_rd.age[w] + 1'b1;
         end
      end
      if (ctrl.clearing) l1_meta_wr = btbf_pkg::l1_meta_reset();
   end

   // Level 2 match, victim choice and age update.
   always_comb begin
      l2_hit = 1'b0; l2_mway = '0; l2_inv = 1'b0; l2_iway = '0; l2_oway = '0;
      for (int w = btbf_pkg::L2_WAYS - 1; w >= 0; w--) begin
         if (l2_meta_rd.valid[w] && (l2_data_rd[w][btbf_pkg::L2_DATA_BITS-1:
                                                   btbf_pkg::L2_TARGET_BITS]
                                     == cur_ff.l2_key)) begin
            l2_hit = 1'b1; l2_mway = btbf_pkg::L2_WAY_BITS'(w);
         end
         if (!l2_meta_rd.valid[w]) begin
            l2_inv = 1'b1; l2_iway = btbf_pkg::L2_WAY_BITS'(w);
         end
         if (l2_meta_rd.age[w] == btbf_pkg::L2_WAY_BITS'(btbf_pkg::L2_WAYS - 1)) begin
            l2_oway = btbf_pkg::L2_WAY_BITS'(w);
         end
      end
      l2_pick = l2_hit ? l2_mway : (l2_inv ? l2_iway : l2_oway);
      l2_mine = l2_meta_rd.age[l2_pick];
      l2_meta_wr = l2_meta_rd;
      for (int w = 0; w < btbf_pkg::L2_WAYS; w++) begin
         if (btbf_pkg::L2_WAY_BITS'(w) == l2_pick) begin
            l2_meta_wr.age[w]   = '0;
            l2_meta_wr.valid[w] = 1'b1;
         end else if (l2_meta_rd.age[w] < l2_mine) begin
            l2_meta_wr.age[w] = l2_meta_rd.age[w] + 1'b1;
         end
      end
      if (ctrl.clearing) l2_meta_wr = btbf_pkg::l2_meta_reset();
   end

   always_comb begin
      l1_meta_we = ctrl.clearing || (commit && en1 && !lookup);
      l2_meta_we = ctrl.clearing || (commit && en2 && !lookup);
      for (int w = 0; w < btbf_pkg::L1_WAYS; w++) begin
         l1_data_we[w] = commit && en1 && !lookup && (l1_pick == btbf_pkg::L1_WAY_BITS'(w));
      end
      for (int w = 0; w < btbf_pkg::L2_WAYS; w++) begin
         l2_data_we[w] = commit && en2 && !lookup && (l2_pick == btbf_pkg::L2_WAY_BITS'(w));
      end
   end

   // Result fields.
   always_comb begin
      l1_hit_in = en1 && l1_hit;
      l1_way_in = '0;
      l1_tgt_in = '0;
      if (en1) begin
         if (!lookup) begin
            l1_way_in = l1_pick;
         end else if (l1_hit) begin
            l1_way_in = l1_mway;
            l1_tgt_in = l1_data_rd[l1_mway][btbf_pkg::ADDR_BITS-1:0];
         end
      end
      l2_hit_in = en2 && l2_hit;
      l2_way_in = '0;
      l2_tgt_in = '0;
      if (en2) begin
         if (!lookup) begin
            l2_way_in = l2_pick;
         end else if (l2_hit) begin
            l2_way_in = l2_mway;
            l2_tgt_in = l2_data_rd[l2_mway][btbf_pkg::L2_TARGET_BITS-1:0];
         end
      end
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_if.ready);
   end

   btbf_ram #(.WIDTH(btbf_pkg::L1_META_BITS), .DEPTH(1 << btbf_pkg::L1_SET_BITS)) u_l1_meta (
      .clock, .wr_en(l1_meta_we), .wr_addr(l1_wr_addr), .wr_data(l1_meta_wr),
      .rd_addr(l1_rd_addr), .rd_data(l1_meta_rd));

   btbf_ram #(.WIDTH(btbf_pkg::L2_META_BITS), .DEPTH(1 << btbf_pkg::L2_SET_BITS)) u_l2_meta (
      .clock, .wr_en(l2_meta_we), .wr_addr(l2_wr_addr), .wr_data(l2_meta_wr),
      .rd_addr(l2_rd_addr), .rd_data(l2_meta_rd));

   for (genvar g = 0; g < btbf_pkg::L1_WAYS; g++) begin : g_l1_way
      btbf_ram #(.WIDTH(btbf_pkg::L1_DATA_BITS), .DEPTH(1 << btbf_pkg::L1_SET_BITS)) u_data (
         .clock, .wr_en(l1_data_we[g]), .wr_addr(cur_ff.l1_set),
         .wr_data({cur_ff.l1_key, cur_ff.target}),
         .rd_addr(l1_rd_addr), .rd_data(l1_data_rd[g]));
   end

   for (genvar g = 0; g < btbf_pkg::L2_WAYS; g++) begin : g_l2_way
      btbf_ram #(.WIDTH(btbf_pkg::L2_DATA_BITS), .DEPTH(1 << btbf_pkg::L2_SET_BITS)) u_data (
         .clock, .wr_en(l2_data_we[g]), .wr_addr(cur_ff.l2_set),
         .wr_data({cur_ff.l2_key, cur_ff.target[btbf_pkg::L2_TARGET_BITS-1:0]}),
         .rd_addr(l2_rd_addr), .rd_data(l2_data_rd[g]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btbf_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (commit) begin
         l1_hit_ff <= l1_hit_in;
         l1_way_ff <= l1_way_in;
         l1_tgt_ff <= l1_tgt_in;
         l2_hit_ff <= l2_hit_in;
         l2_way_ff <= l2_way_in;
         l2_tgt_ff <= l2_tgt_in;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.l1_hit           = l1_hit_ff;
   assign rsp_if.l1_way           = l1_way_ff;
   assign rsp_if.l1_stored_target = l1_tgt_ff;
   assign rsp_if.l2_hit           = l2_hit_ff;
   assign rsp_if.l2_way           = l2_way_ff;
   assign rsp_if.l2_stored_target = l2_tgt_ff;
endmodule

// ===== hdl/two_level_btb_fill_lru_top.sv =====
// Two-level branch target buffer with least-recently-used fill.
// Transactions enter on req_if (kind, level, branch address, target) with a
// valid/ready handshake and each one returns exactly one transaction on rsp_if
// carrying hit, way and stored target for both levels, in request order.
// The front classifies the address into level 1 and level 2 set and tag and
// parks the transaction in a two-entry queue. The back reads the set's age,
// valid and way data memories, then from the registered read data matches,
// picks a victim and, once the output register is free, writes the set back and
// loads the output register. The back handles one transaction at a time: it pops
// no new queue entry until the current one commits, while the queue can still
// accept requests.
// After reset the back sweeps the age/valid memories one set a cycle over all
// 1024 set indices; req_if.ready stays low during that sweep.
// When the receiver stalls, the result holds in the output register, the back
// waits before committing the next transaction, and the queue keeps accepting
// until both of its entries are full.
`include "two_level_btb_fill_lru_top_assert.svh"

module two_level_btb_fill_lru_top (
   input logic        clock,
   input logic        reset,
   btbf_req_if.sink   req_if,
   btbf_rsp_if.source rsp_if
);
   // Queue head from front to back, and pop/clear status from back to front.
   btbf_pkg::head_type head;
   btbf_pkg::ctrl_type ctrl;

   btbf_front u_front (
      .clock,
      .reset,
      .req_if,
      .ctrl,
      .head
   );

   btbf_back u_back (
      .clock,
      .reset,
      .head,
      .ctrl,
      .rsp_if
   );

   // No transaction is taken in while the set memories are being cleared.
   `BTBF_ASSERT(a_no_accept_in_clear, clock, reset, ctrl.clearing |-> !req_if.ready)
   // The back only pops a queue entry that is present.
   `BTBF_ASSERT(a_pop_needs_entry, clock, reset, ctrl.pop |-> head.valid)
   // The first cycle after the clearing sweep carries no result.
   `BTBF_ASSERT(a_no_rsp_after_clear, clock, reset, $fell(ctrl.clearing) |-> !rsp_if.valid)
endmodule
